[rtl/core/twtp_pkg.sv]
package twtp_pkg;

	localparam int COLUMN_BITS = 16;
	localparam int TOTAL_BITS = 26;
	localparam int MIN_PROFILE = 3;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	typedef enum logic [6:0] {
		S_LOAD   = 7'b0000001,
		S_START  = 7'b0000010,
		S_PEAK_L = 7'b0000100,
		S_PEAK_R = 7'b0001000,
		S_READ   = 7'b0010000,
		S_UPD    = 7'b0100000,
		S_OUT    = 7'b1000000
	} walk_state_t;

endpackage

[rtl/core/twtp_store.sv]
module twtp_store #(
	parameter int DEPTH = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/twtp_step_unit.sv]
module twtp_step_unit #(
	parameter int DATA_W = 16
) (
	input  logic [DATA_W-1:0] op_a,
	input  logic [DATA_W-1:0] op_b,
	output logic              a_below,
	output logic [DATA_W-1:0] gap
);

	logic [DATA_W:0] diff;

	// One subtractor serves both the peak comparison and the water depth.
	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign a_below = diff[DATA_W];
	assign gap = diff[DATA_W] ? '0 : diff[DATA_W-1:0];

endmodule

[rtl/core/trapped_water_two_pointer.sv]
// Loading: one column per cycle, one request accepted each cycle while loading.
// Walk: after the request with last_column, the block reads both end peaks and then
// steps the pointers inward; each pointer step passes through a read state and an
// update state because the height store has a registered read.
// Profiles shorter than three columns go straight from the start state to the output state.
// Reset (arst_n low, asynchronous) clears all control state; the store is not cleared.
module trapped_water_two_pointer #(
	parameter int MAX_COLUMNS = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 col_valid,
	output logic                                 col_stall,
	input  logic [twtp_pkg::COLUMN_BITS-1:0]     column_height,
	input  logic                                 last_column,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [twtp_pkg::TOTAL_BITS-1:0]      water_total,
	output logic                                 overflow_flag
);

	import twtp_pkg::*;

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int ADDR_W = $clog2(MAX_COLUMNS);
	localparam int SUM_W = ((HEIGHT_BITS > TOTAL_BITS) ? HEIGHT_BITS : TOTAL_BITS) + 1;

	walk_state_t state_q;
	logic [CNT_W-1:0] column_count_q;
	logic dropped_q;
	logic [HEIGHT_BITS-1:0] left_peak_q;
	logic [HEIGHT_BITS-1:0] right_peak_q;
	logic [CNT_W-1:0] left_index_q;
	logic [CNT_W-1:0] right_index_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [HEIGHT_BITS-1:0] gap_q;
	logic side_left_q;
	logic res_valid_q;
	logic [TOTAL_BITS-1:0] water_total_q;
	logic overflow_q;

	logic col_acc;
	logic room;
	logic wr_en;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [HEIGHT_BITS-1:0] rd_data;
	logic [HEIGHT_BITS-1:0] unit_a;
	logic [HEIGHT_BITS-1:0] unit_b;
	logic unit_below;
	logic [HEIGHT_BITS-1:0] unit_gap;
	logic [SUM_W-1:0] sum;
	logic [TOTAL_BITS-1:0] total_next;
	logic [CNT_W-1:0] last_index;
	logic out_free;

	assign col_stall = (state_q != S_LOAD);
	assign col_acc = col_valid && !col_stall;
	assign room = (column_count_q < CNT_W'(MAX_COLUMNS));
	assign wr_en = col_acc && room;
	assign last_index = column_count_q - CNT_W'(1);
	assign out_free = !res_valid_q || !res_stall;

	assign sum = SUM_W'(total_q) + SUM_W'(gap_q);
	assign total_next = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

	twtp_store #(
		.DEPTH (MAX_COLUMNS),
		.ADDR_W(ADDR_W),
		.DATA_W(HEIGHT_BITS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(column_count_q[ADDR_W-1:0]),
		.wr_data(HEIGHT_BITS'(column_height)),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	twtp_step_unit #(
		.DATA_W(HEIGHT_BITS)
	) u_step (
		.op_a   (unit_a),
		.op_b   (unit_b),
		.a_below(unit_below),
		.gap    (unit_gap)
	);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		unit_a = left_peak_q;
		unit_b = right_peak_q;
		unique case (state_q)
			S_START: begin
				rd_en = 1'b1;
			end
			S_PEAK_L: begin
				rd_en = 1'b1;
				rd_addr = last_index[ADDR_W-1:0];
			end
			S_READ: begin
				// Left moves only when its peak is strictly lower; ties go right.
				rd_en = 1'b1;
				rd_addr = unit_below ? left_index_q[ADDR_W-1:0] : right_index_q[ADDR_W-1:0];
			end
			S_UPD: begin
				unit_a = side_left_q ? left_peak_q : right_peak_q;
				unit_b = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			column_count_q <= '0;
			dropped_q <= 1'b0;
			left_peak_q <= '0;
			right_peak_q <= '0;
			left_index_q <= '0;
			right_index_q <= '0;
			total_q <= '0;
			side_left_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (col_acc) begin
						if (room) begin
							column_count_q <= column_count_q + CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_column) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					total_q <= '0;
					left_index_q <= CNT_W'(1);
					right_index_q <= column_count_q - CNT_W'(2);
					if (column_count_q < CNT_W'(MIN_PROFILE)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_PEAK_L;
					end
				end
				S_PEAK_L: begin
					left_peak_q <= rd_data;
					state_q <= S_PEAK_R;
				end
				S_PEAK_R: begin
					right_peak_q <= rd_data;
					state_q <= S_READ;
				end
				S_READ: begin
					total_q <= total_next;
					side_left_q <= unit_below;
					if (left_index_q > right_index_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (side_left_q) begin
						if (unit_below) begin
							left_peak_q <= rd_data;
						end
						left_index_q <= left_index_q + CNT_W'(1);
					end else begin
						if (unit_below) begin
							right_peak_q <= rd_data;
						end
						right_index_q <= right_index_q - CNT_W'(1);
					end
					state_q <= S_READ;
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						column_count_q <= '0;
						dropped_q <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// The depth of the last visited column is added on the following pointer step.
	always_ff @(posedge clk) begin
		if (state_q == S_PEAK_R) begin
			gap_q <= '0;
		end else if (state_q == S_UPD) begin
			gap_q <= unit_gap;
		end
		if (state_q == S_OUT && out_free) begin
			water_total_q <= total_q;
			overflow_q <= dropped_q;
		end
	end

	assign res_valid = res_valid_q;
	assign water_total = water_total_q;
	assign overflow_flag = overflow_q;

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		column_count_q <= CNT_W'(MAX_COLUMNS))
		else $error("column count beyond store depth");

	a_pointer_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (left_index_q <= right_index_q))
		else $error("pointers crossed during a step");

	a_upd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $past(state_q == S_READ))
		else $error("update without a preceding store read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> res_valid_q && $stable(water_total_q))
		else $error("pending result overwritten");

endmodule

[bench/water_checker.sv]
`timescale 1ns / 1ps

module water_checker #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            col_valid,
	input  logic                            col_stall,
	input  logic [twtp_pkg::COLUMN_BITS-1:0] column_height,
	input  logic                            last_column,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  logic [twtp_pkg::TOTAL_BITS-1:0]  water_total,
	input  logic                            overflow_flag,
	output int                              mismatches,
	output int                              awaiting
);

	import twtp_pkg::*;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] water;
		logic                  dropped;
	} basin_result_t;

	basin_result_t           expected_basins[$];
	logic [COLUMN_BITS-1:0]  heights[STORE_DEPTH];
	int unsigned             stored_columns;
	logic                    dropped_columns;
	int                      error_count;

	// Two pointers move inward; the side with the lower peak steps, the right side on a tie.
	function automatic logic [TOTAL_BITS-1:0] trapped_water(input int unsigned n);
		logic [COLUMN_BITS-1:0] left_top;
		logic [COLUMN_BITS-1:0] right_top;
		logic [COLUMN_BITS-1:0] h;
		int unsigned            lo;
		int unsigned            hi;
		logic [63:0]            sum;
		sum = '0;
		if (n < MIN_PROFILE)
			return '0;
		left_top = heights[0];
		right_top = heights[n - 1];
		lo = 1;
		hi = n - 2;
		while (lo <= hi) begin
			if (left_top < right_top) begin
				h = heights[lo];
				if (left_top > h)
					sum += left_top - h;
				else
					left_top = h;
				lo++;
			end else begin
				h = heights[hi];
				if (right_top > h)
					sum += right_top - h;
				else
					right_top = h;
				hi--;
			end
			if (sum > TOTAL_MAX)
				sum = TOTAL_MAX;
		end
		return sum[TOTAL_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		basin_result_t want;
		if (!arst_n) begin
			stored_columns = 0;
			dropped_columns = 1'b0;
		end else begin
			if ($isunknown(res_valid)) begin
				$display("%0t: res_valid expected 0 or 1, actual %b", $time, res_valid);
				error_count++;
			end
			if (res_valid && !res_stall) begin
				if (expected_basins.size() == 0) begin
					$display("%0t: result expected none, actual water_total %0d overflow_flag %b",
						$time, water_total, overflow_flag);
					error_count++;
				end else begin
					want = expected_basins.pop_front();
					if (water_total !== want.water) begin
						$display("%0t: water_total expected %0d, actual %0d",
							$time, want.water, water_total);
						error_count++;
					end
					if (overflow_flag !== want.dropped) begin
						$display("%0t: overflow_flag expected %b, actual %b",
							$time, want.dropped, overflow_flag);
						error_count++;
					end
				end
			end
			if (col_valid && !col_stall) begin
				if (stored_columns < STORE_DEPTH) begin
					heights[stored_columns] = column_height;
					stored_columns++;
				end else begin
					dropped_columns = 1'b1;
				end
				if (last_column) begin
					want.water = trapped_water(stored_columns);
					want.dropped = dropped_columns;
					expected_basins.push_back(want);
					stored_columns = 0;
					dropped_columns = 1'b0;
				end
			end
		end
		awaiting <= expected_basins.size();
		mismatches <= error_count;
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	import twtp_pkg::*;

	localparam int STORE_DEPTH     = 1024;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PRESSURE_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 64;
	localparam int RANDOM_ITEMS    = 400;
	localparam int RANDOM_PROFILES = 40;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_SHALLOW,
		SHAPE_EXTREME,
		SHAPE_VALLEY,
		SHAPE_DEEP,
		SHAPE_RISE,
		SHAPE_FALL,
		SHAPE_FLAT,
		SHAPE_COUNT
	} profile_shape_t;

	logic                    clk;
	logic                    arst_n;
	logic                    col_valid;
	logic                    col_stall;
	logic [COLUMN_BITS-1:0]  column_height;
	logic                    last_column;
	logic                    res_valid;
	logic                    res_stall;
	logic [TOTAL_BITS-1:0]   water_total;
	logic                    overflow_flag;
	int                      mismatches;
	int                      awaiting;
	int                      cycle_count = 0;
	logic                    steady_sender = 1'b0;
	logic                    steady_sink = 1'b0;
	logic                    hold_off_request = 1'b0;

	trapped_water_two_pointer #(
		.MAX_COLUMNS(STORE_DEPTH),
		.HEIGHT_BITS(COLUMN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.col_valid(col_valid),
		.col_stall(col_stall),
		.column_height(column_height),
		.last_column(last_column),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.water_total(water_total),
		.overflow_flag(overflow_flag)
	);

	water_checker #(
		.STORE_DEPTH(STORE_DEPTH)
	) water_check (
		.clk(clk),
		.arst_n(arst_n),
		.col_valid(col_valid),
		.col_stall(col_stall),
		.column_height(column_height),
		.last_column(last_column),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.water_total(water_total),
		.overflow_flag(overflow_flag),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int sender_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_sender || roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [COLUMN_BITS-1:0] column_for(input profile_shape_t shape,
			input int idx, input int len);
		case (shape)
			SHAPE_SHALLOW: return COLUMN_BITS'($urandom_range(0, 15));
			SHAPE_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
			SHAPE_VALLEY:  return (idx == 0 || idx == len - 1) ? '1 :
				COLUMN_BITS'($urandom_range(0, 65535));
			SHAPE_DEEP:    return (idx == 0 || idx == len - 1) ? '1 : '0;
			SHAPE_RISE:    return COLUMN_BITS'(idx * 613);
			SHAPE_FALL:    return COLUMN_BITS'(65535 - idx * 613);
			SHAPE_FLAT:    return 16'h8000;
			default:       return COLUMN_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// Holds the request until it is taken; valid stays high across back-to-back requests.
	task automatic send_column(input logic [COLUMN_BITS-1:0] h, input logic last);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			col_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		col_valid <= 1'b1;
		column_height <= h;
		last_column <= last;
		@(posedge clk);
		while (col_stall)
			@(posedge clk);
	endtask

	task automatic send_profile(input int len, input profile_shape_t shape);
		for (int i = 0; i < len; i++)
			send_column(column_for(shape, i, len), i == len - 1);
	endtask

	initial begin : result_sink
		int roll;
		int hold;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				// Long hold-off: the block finishes its walk and must stall new requests.
				res_stall <= 1'b1;
				for (hold = 0; hold < PRESSURE_CYCLES; hold++)
					@(posedge clk);
				hold_off_request = 1'b0;
			end else begin
				if ($urandom_range(0, 199) == 0)
					steady_sink = !steady_sink;
				roll = $urandom_range(0, 99);
				if (steady_sink || roll < 60) begin
					res_stall <= 1'b0;
				end else if (roll < 95) begin
					res_stall <= 1'b1;
				end else begin
					res_stall <= 1'b1;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	initial begin : column_source
		int items;
		int profiles;
		int len;
		int roll;
		col_valid = 1'b0;
		column_height = '0;
		last_column = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short profiles, the widest valleys and a tie between the two peaks.
		send_column(16'hFFFF, 1'b1);
		send_column(16'h0000, 1'b0);
		send_column(16'hFFFF, 1'b1);
		send_column(16'hFFFF, 1'b0);
		send_column(16'h0000, 1'b0);
		send_column(16'hFFFF, 1'b1);
		send_column(16'h0000, 1'b0);
		send_column(16'hFFFF, 1'b0);
		send_column(16'h0000, 1'b1);
		send_column(16'd5, 1'b0);
		send_column(16'd2, 1'b0);
		send_column(16'd5, 1'b1);
		send_profile(5, SHAPE_VALLEY);
		send_profile(4, SHAPE_RISE);
		send_profile(4, SHAPE_FALL);

		// A store filled exactly, then profiles whose tail is dropped.
		steady_sender = 1'b1;
		send_profile(STORE_DEPTH, SHAPE_DEEP);
		steady_sender = 1'b0;
		send_profile(STORE_DEPTH + 1, SHAPE_VALLEY);
		send_profile(STORE_DEPTH + 6, SHAPE_NOISE);
		send_profile(8, SHAPE_SHALLOW);

		items = 0;
		profiles = 0;
		while (items < RANDOM_ITEMS || profiles < RANDOM_PROFILES) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				len = $urandom_range(1, 12);
			else if (roll < 95)
				len = $urandom_range(13, 60);
			else
				len = $urandom_range(61, 200);
			steady_sender = ($urandom_range(0, 9) == 0);
			if (profiles == 3 || profiles == 25)
				hold_off_request = 1'b1;
			send_profile(len, profile_shape_t'($urandom_range(0, SHAPE_COUNT - 1)));
			items += len;
			profiles++;
		end

		col_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
